FILE: rtl/bdda_pkg.sv
`default_nettype none

package bdda_pkg;

    localparam int DAYS_WIDTH_DEF = 10;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int BDAYS_W = 10;
    localparam int WD_W    = 3;
    localparam int MODE_W  = 2;

    // remainder of the shared unit; below 400
    localparam int REM_W   = 10;
    // quotient of a 14-bit value by 7
    localparam int QUO_W   = 12;
    localparam int RECIP_W = 19;
    localparam int RECIP_SHIFT = 21;
    localparam int PROD_W  = YEAR_W + RECIP_W;
    localparam int QD_W    = QUO_W + REM_W;
    localparam int STEP_W  = 1;
    localparam logic [STEP_W-1:0] LAST_STEP = 1'b1;

    localparam logic [REM_W-1:0] DIV_400 = REM_W'(400);
    localparam logic [REM_W-1:0] DIV_7   = REM_W'(7);

    // ceil(2^21 / divisor): exact floor quotient for any 14-bit dividend
    localparam logic [RECIP_W-1:0] RECIP_400 = RECIP_W'(5243);
    localparam logic [RECIP_W-1:0] RECIP_7   = RECIP_W'(299594);

    // weekend_mode codes
    localparam logic [MODE_W-1:0] WEEKEND_FRI = 2'd0;
    localparam logic [MODE_W-1:0] WEEKEND_SAT = 2'd1;
    localparam logic [MODE_W-1:0] WEEKEND_BOTH = 2'd2;

    // day of week codes
    localparam logic [WD_W-1:0] SUNDAY   = 3'd0;
    localparam logic [WD_W-1:0] FRIDAY   = 3'd5;
    localparam logic [WD_W-1:0] SATURDAY = 3'd6;

    localparam logic [MONTH_W-1:0] JANUARY  = 4'd1;
    localparam logic [MONTH_W-1:0] FEBRUARY = 4'd2;
    localparam logic [MONTH_W-1:0] DECEMBER = 4'd12;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV400,
        ST_CHECK,
        ST_MOD7,
        ST_WALK,
        ST_FINISH
    } state_t;

    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
        logic [DAY_W-1:0] r;
        case (m)
            4'd2:                   r = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
            default:                r = 5'd31;
        endcase
        return r;
    endfunction

    // (31 * mm) / 12 for mm in 1..12
    function automatic logic [DAY_W-1:0] month_term(input logic [MONTH_W-1:0] mm);
        logic [DAY_W-1:0] r;
        case (mm)
            4'd1:    r = 5'd2;
            4'd2:    r = 5'd5;
            4'd3:    r = 5'd7;
            4'd4:    r = 5'd10;
            4'd5:    r = 5'd12;
            4'd6:    r = 5'd15;
            4'd7:    r = 5'd18;
            4'd8:    r = 5'd20;
            4'd9:    r = 5'd23;
            4'd10:   r = 5'd25;
            4'd11:   r = 5'd28;
            4'd12:   r = 5'd31;
            default: r = 5'd0;
        endcase
        return r;
    endfunction

    // yy / 100 for yy below 800
    function automatic logic [2:0] div100(input logic [REM_W-1:0] yy);
        logic [2:0] q;
        if (yy >= 10'd700)      q = 3'd7;
        else if (yy >= 10'd600) q = 3'd6;
        else if (yy >= 10'd500) q = 3'd5;
        else if (yy >= 10'd400) q = 3'd4;
        else if (yy >= 10'd300) q = 3'd3;
        else if (yy >= 10'd200) q = 3'd2;
        else if (yy >= 10'd100) q = 3'd1;
        else                    q = 3'd0;
        return q;
    endfunction

    function automatic logic is_weekend(input logic [MODE_W-1:0] mode,
                                        input logic [WD_W-1:0] wd);
        logic r;
        case (mode)
            WEEKEND_FRI: r = (wd == FRIDAY);
            WEEKEND_SAT: r = (wd == SATURDAY);
            default:     r = (wd == FRIDAY) || (wd == SATURDAY);
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/business_day_date_adder.sv
`default_nettype none

// Sequence: year mod 400 by the shared remainder unit, check, weekday sum mod 7 by
// the same unit, then one calendar day walked per cycle until the business days are
// used up and no weekend remains; the result loads in the finish state once the
// output register is free. A bad date goes from check straight to the finish state.
// One transaction at a time: the shared remainder unit and the day stepper are busy.
// Reset (rst_n low, async): idle, no result pending, weekend_mode = 2.

module business_day_date_adder
    import bdda_pkg::*;
#(
    parameter int DAYS_WIDTH = DAYS_WIDTH_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    // input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [13:0] start_year, [17:14] start_month, [22:18] start_day,
    // [32:23] business_days, [39:33] zero
    input  wire logic [39:0] s_axis_tdata,

    // result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [13:0] return_year, [17:14] return_month, [22:18] return_day,
    // [25:23] weekday, [26] bad_date, [31:27] zero
    output logic [31:0]      m_axis_tdata,

    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [MODE_W-1:0] mode_reg;
    logic              cfg_hit;

    assign pready  = 1'b1;
    assign cfg_hit = (paddr[2] == 1'b0);
    assign prdata  = cfg_hit ? {30'd0, mode_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= WEEKEND_BOTH;
        end
        else if (psel && penable && pwrite && pready && cfg_hit)
        begin
            mode_reg <= pwdata[MODE_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Input field split
    // ------------------------------------------------------------------
    logic [YEAR_W-1:0]  in_year;
    logic [MONTH_W-1:0] in_month;
    logic [DAY_W-1:0]   in_day;
    logic [BDAYS_W-1:0] in_bdays;

    assign in_year  = s_axis_tdata[13:0];
    assign in_month = s_axis_tdata[17:14];
    assign in_day   = s_axis_tdata[22:18];
    assign in_bdays = s_axis_tdata[32:23];

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t              state_reg, state_next;
    logic [YEAR_W-1:0]   y_reg, y_next;
    logic [MONTH_W-1:0]  m_reg, m_next;
    logic [DAY_W-1:0]    d_reg, d_next;
    logic [DAYS_WIDTH-1:0] n_reg, n_next;
    logic [WD_W-1:0]     wd_reg, wd_next;
    logic [8:0]          r400_reg, r400_next;     // year mod 400
    logic [6:0]          r100_reg, r100_next;     // year mod 100
    logic                bad_reg, bad_next;

    // shared remainder unit: quotient estimate, then remainder
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic [YEAR_W-1:0]   dvd_reg, dvd_next;
    logic [QUO_W-1:0]    quo_reg, quo_next;
    logic [STEP_W-1:0]   cnt_reg, cnt_next;

    logic                out_valid_reg, out_valid_next;
    logic [YEAR_W-1:0]   out_y_reg, out_y_next;
    logic [MONTH_W-1:0]  out_m_reg, out_m_next;
    logic [DAY_W-1:0]    out_d_reg, out_d_next;
    logic [WD_W-1:0]     out_wd_reg, out_wd_next;
    logic                out_bad_reg, out_bad_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        y_reg       <= y_next;
        m_reg       <= m_next;
        d_reg       <= d_next;
        n_reg       <= n_next;
        wd_reg      <= wd_next;
        r400_reg    <= r400_next;
        r100_reg    <= r100_next;
        bad_reg     <= bad_next;
        rem_reg     <= rem_next;
        dvd_reg     <= dvd_next;
        quo_reg     <= quo_next;
        cnt_reg     <= cnt_next;
        out_y_reg   <= out_y_next;
        out_m_reg   <= out_m_next;
        out_d_reg   <= out_d_next;
        out_wd_reg  <= out_wd_next;
        out_bad_reg <= out_bad_next;
    end

    // ------------------------------------------------------------------
    // Shared remainder unit: divisor 400 for the year, 7 for the weekday.
    // First step: quotient by reciprocal multiply. Second: dividend minus
    // quotient times divisor.
    // ------------------------------------------------------------------
    logic [REM_W-1:0]   divisor;
    logic [RECIP_W-1:0] recip;
    logic [PROD_W-1:0]  product;
    logic [QUO_W-1:0]   quo_est;
    logic [QD_W-1:0]    quo_mul;
    logic [YEAR_W-1:0]  rem_full;
    logic [REM_W-1:0]   rem_step;

    assign divisor  = (state_reg == ST_MOD7) ? DIV_7 : DIV_400;
    assign recip    = (state_reg == ST_MOD7) ? RECIP_7 : RECIP_400;
    assign product  = PROD_W'(dvd_reg) * PROD_W'(recip);
    assign quo_est  = product[RECIP_SHIFT +: QUO_W];
    assign quo_mul  = QD_W'(quo_reg) * QD_W'(divisor);
    assign rem_full = dvd_reg - quo_mul[YEAR_W-1:0];
    assign rem_step = rem_full[REM_W-1:0];

    // ------------------------------------------------------------------
    // Check stage: leap year, range check and weekday sum.
    // Day of week repeats every 400 years, so year mod 400 stands in for
    // the year; the sum is reduced mod 7 by the shared unit afterwards.
    // ------------------------------------------------------------------
    logic [8:0]       c_r400;
    logic [6:0]       c_r100;
    logic             c_leap;
    logic [DAY_W-1:0] c_dim;
    logic             c_bad;
    logic             c_early;          // January or February
    logic [REM_W-1:0] c_yy;
    logic [MONTH_W-1:0] c_mm;
    logic [10:0]      c_sum;

    always_comb
    begin
        c_r400 = rem_reg[8:0];
        if (c_r400 >= 9'd300)      c_r100 = 7'(c_r400 - 9'd300);
        else if (c_r400 >= 9'd200) c_r100 = 7'(c_r400 - 9'd200);
        else if (c_r400 >= 9'd100) c_r100 = 7'(c_r400 - 9'd100);
        else                       c_r100 = c_r400[6:0];
        c_leap  = ((y_reg[1:0] == 2'd0) && (c_r100 != 7'd0)) || (c_r400 == 9'd0);
        c_dim   = month_days(m_reg, c_leap);
        c_bad   = !(m_reg inside {[JANUARY:DECEMBER]}) || (d_reg == '0) || (d_reg > c_dim);
        c_early = (m_reg <= FEBRUARY);
        c_yy    = REM_W'(c_r400) + DIV_400 - REM_W'(c_early);
        c_mm    = c_early ? MONTH_W'(m_reg + 4'd10) : MONTH_W'(m_reg - 4'd2);
        c_sum   = 11'(d_reg) + 11'(c_yy) + 11'(c_yy >> 2) + 11'(c_yy >= DIV_400)
                + 11'(month_term(c_mm)) - 11'(div100(c_yy));
    end

    // ------------------------------------------------------------------
    // Walk stage: one calendar day per cycle
    // ------------------------------------------------------------------
    logic             w_leap;
    logic [DAY_W-1:0] w_dim;
    logic             w_weekend;

    assign w_leap    = ((y_reg[1:0] == 2'd0) && (r100_reg != 7'd0)) || (r400_reg == 9'd0);
    assign w_dim     = month_days(m_reg, w_leap);
    assign w_weekend = is_weekend(mode_reg, wd_reg);

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        y_next         = y_reg;
        m_next         = m_reg;
        d_next         = d_reg;
        n_next         = n_reg;
        wd_next        = wd_reg;
        r400_next      = r400_reg;
        r100_next      = r100_reg;
        bad_next       = bad_reg;
        rem_next       = rem_reg;
        dvd_next       = dvd_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_y_next     = out_y_reg;
        out_m_next     = out_m_reg;
        out_d_next     = out_d_reg;
        out_wd_next    = out_wd_reg;
        out_bad_next   = out_bad_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    y_next     = in_year;
                    m_next     = in_month;
                    d_next     = in_day;
                    n_next     = DAYS_WIDTH'(in_bdays);
                    rem_next   = '0;
                    dvd_next   = in_year;
                    cnt_next   = '0;
                    state_next = ST_DIV400;
                end
            end

            ST_DIV400, ST_MOD7:
            begin
                quo_next = quo_est;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP)
                begin
                    rem_next = rem_step;
                    if (state_reg == ST_DIV400)
                    begin
                        state_next = ST_CHECK;
                    end
                    else
                    begin
                        wd_next    = rem_step[WD_W-1:0];
                        state_next = ST_WALK;
                    end
                end
            end

            ST_CHECK:
            begin
                r400_next = c_r400;
                r100_next = c_r100;
                bad_next  = c_bad;
                if (c_bad)
                begin
                    wd_next    = SUNDAY;
                    state_next = ST_FINISH;
                end
                else
                begin
                    rem_next   = '0;
                    dvd_next   = YEAR_W'(c_sum);
                    cnt_next   = '0;
                    state_next = ST_MOD7;
                end
            end

            ST_WALK:
            begin
                if ((n_reg != '0) || w_weekend)
                begin
                    if ((n_reg != '0) && !w_weekend)
                    begin
                        n_next = n_reg - 1'b1;
                    end
                    wd_next = (wd_reg == SATURDAY) ? SUNDAY : WD_W'(wd_reg + 3'd1);
                    if (d_reg == w_dim)
                    begin
                        d_next = DAY_W'(1);
                        if (m_reg == DECEMBER)
                        begin
                            m_next    = JANUARY;
                            y_next    = y_reg + 1'b1;
                            r400_next = (r400_reg == 9'd399) ? 9'd0 : r400_reg + 9'd1;
                            r100_next = (r100_reg == 7'd99) ? 7'd0 : r100_reg + 7'd1;
                        end
                        else
                        begin
                            m_next = m_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        d_next = d_reg + 1'b1;
                    end
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_y_next     = y_reg;
                    out_m_next     = m_reg;
                    out_d_next     = d_reg;
                    out_wd_next    = wd_reg;
                    out_bad_next   = bad_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, out_bad_reg, out_wd_reg, out_d_reg, out_m_reg, out_y_reg};

endmodule

`default_nettype wire
